// File: rtl/core/pbfp_pkg.sv
// ----------------------------------------------------------------------------
// pbfp_pkg
// Shared constants and types for the parity bit frame packer.
// ----------------------------------------------------------------------------
package pbfp_pkg;

  // frame size limit and derived bit count widths
  localparam int MAX_FRAME_BYTES = 256;
  localparam int BIT_LIMIT       = MAX_FRAME_BYTES * 8;
  localparam int TOTAL_W         = $clog2(BIT_LIMIT + 1);
  localparam int SUM_W           = TOTAL_W + 1;
  localparam int FB_W            = 12;
  localparam int WIDE_W          = (SUM_W > FB_W) ? SUM_W : FB_W;

  // air format
  localparam int DATA_W     = 8;
  localparam int LB_W       = 4;
  localparam int PEND_CNT_W = 3;
  localparam int ACC_W      = 16;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one queue entry: one or two output words produced by one input word
  typedef struct packed {
    logic [DATA_W-1:0] byte0;
    logic [DATA_W-1:0] byte1;
    logic              two;
    logic              last;
    logic [FB_W-1:0]   bits;
  } pbfp_entry_t;

endpackage

// File: rtl/core/parity_bit_frame_packer.sv
// The first frame byte of an input word is registered in the queue and then
// in the output register. Input takes one word per cycle while the queue has
// room; the single output register moves one frame byte a cycle while the
// output is taken, so a word with two frame bytes holds it for both bytes.
// The two entry queue between front and back sets how far input runs ahead.
// Reset clears the pending bits, the bit total and all valid flags.
// ----------------------------------------------------------------------------
// parity_bit_frame_packer
// Packs data bytes and their parity bits into LSB first frame bytes.
// ----------------------------------------------------------------------------
module parity_bit_frame_packer import pbfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] data_byte,
  input  logic              parity_bit,
  input  logic              last_byte,
  input  logic [LB_W-1:0]   last_bits,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] frame_byte,
  output logic              frame_end,
  output logic [FB_W-1:0]   frame_bits
);

  logic        push;
  logic        push_ready;
  pbfp_entry_t push_entry;
  logic        pop_valid;
  logic        pop;
  pbfp_entry_t pop_entry;

  // front: parity insertion and byte split
  pbfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .parity_bit (parity_bit),
    .last_byte  (last_byte),
    .last_bits  (last_bits),
    .push       (push),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // queue
  pbfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_entry  (pop_entry)
  );

  // back: output sequencing
  pbfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .frame_end  (frame_end),
    .frame_bits (frame_bits)
  );

endmodule

// File: rtl/core/pbfp_front.sv
// ----------------------------------------------------------------------------
// pbfp_front
// Accepts input words, inserts parity bits and splits the air bit stream
// into one or two frame bytes per word, which it pushes into the queue.
// ----------------------------------------------------------------------------
module pbfp_front import pbfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] data_byte,
  input  logic              parity_bit,
  input  logic              last_byte,
  input  logic [LB_W-1:0]   last_bits,
  output logic              push,
  input  logic              push_ready,
  output pbfp_entry_t       push_entry
);

  logic [DATA_W-1:0]     pending_bits;
  logic [PEND_CNT_W-1:0] pending_count;
  logic                  at_frame_start;
  logic [TOTAL_W-1:0]    data_bit_total;

  logic [LB_W-1:0]   lb;
  logic [ACC_W-1:0]  acc;
  logic [SUM_W-1:0]  add8;
  logic [SUM_W-1:0]  add_lb;
  logic [TOTAL_W-1:0] total_sat;
  logic [TOTAL_W-1:0] total_last;
  logic [WIDE_W-1:0] fbits_wide;
  logic [4:0]        valid_cnt;

  assign in_ready = push_ready;
  assign push     = in_valid & push_ready;

  // out of range bit counts mean a full byte
  assign lb = (last_bits == '0 || last_bits > LB_W'(8)) ? LB_W'(8) : last_bits;

  // pending bits, then data, then parity
  assign acc = {{(ACC_W-DATA_W){1'b0}}, pending_bits}
             | ({{(ACC_W-DATA_W){1'b0}}, data_byte} << pending_count)
             | ({{(ACC_W-1){1'b0}}, parity_bit} << ({1'b0, pending_count} + 4'd8));

  // saturating data bit totals
  assign add8      = {1'b0, data_bit_total} + SUM_W'(8);
  assign total_sat = (add8 > SUM_W'(BIT_LIMIT)) ? TOTAL_W'(BIT_LIMIT) : add8[TOTAL_W-1:0];
  assign add_lb    = {1'b0, data_bit_total} + SUM_W'(lb);
  assign total_last = (add_lb > SUM_W'(BIT_LIMIT)) ? TOTAL_W'(BIT_LIMIT)
                                                   : add_lb[TOTAL_W-1:0];
  assign fbits_wide = WIDE_W'(total_last) + WIDE_W'(total_last >> 3);

  // bits that land in the final bytes
  assign valid_cnt = 5'(pending_count) + 5'(lb) + ((lb == LB_W'(8)) ? 5'd1 : 5'd0);

  // build the queue entry
  always_comb begin
    push_entry = '0;
    if (last_byte && at_frame_start) begin
      push_entry.byte0 = data_byte;
      push_entry.last  = 1'b1;
      push_entry.bits  = FB_W'(lb);
    end else if (!last_byte) begin
      push_entry.byte0 = acc[7:0];
      push_entry.byte1 = acc[15:8];
      push_entry.two   = (pending_count == 3'd7);
    end else begin
      push_entry.byte0 = acc[7:0];
      push_entry.byte1 = acc[15:8];
      push_entry.two   = (valid_cnt > 5'd8);
      push_entry.last  = 1'b1;
      push_entry.bits  = fbits_wide[FB_W-1:0];
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits   <= '0;
      pending_count  <= '0;
      at_frame_start <= 1'b1;
      data_bit_total <= '0;
    end else if (push) begin
      if (last_byte) begin
        pending_bits   <= '0;
        pending_count  <= '0;
        at_frame_start <= 1'b1;
        data_bit_total <= '0;
      end else begin
        at_frame_start <= 1'b0;
        data_bit_total <= total_sat;
        if (pending_count == 3'd7) begin
          pending_bits  <= '0;
          pending_count <= '0;
        end else begin
          pending_bits  <= acc[15:8];
          pending_count <= pending_count + 3'd1;
        end
      end
    end
  end

endmodule

// File: rtl/core/pbfp_queue.sv
// ----------------------------------------------------------------------------
// pbfp_queue
// Short queue of packed entries between the front and the back.
// ----------------------------------------------------------------------------
module pbfp_queue import pbfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        push_ready,
  input  pbfp_entry_t push_entry,
  output logic        pop_valid,
  input  logic        pop,
  output pbfp_entry_t pop_entry
);

  pbfp_entry_t         entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/pbfp_back.sv
// ----------------------------------------------------------------------------
// pbfp_back
// Drains queue entries into the output register, one frame byte a cycle while
// out_ready allows, holding a two byte entry's second byte until the first goes.
// ----------------------------------------------------------------------------
module pbfp_back import pbfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop,
  input  pbfp_entry_t       pop_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] frame_byte,
  output logic              frame_end,
  output logic [FB_W-1:0]   frame_bits
);

  logic              load;
  logic              hold;
  logic [DATA_W-1:0] hold_byte;
  logic              hold_end;
  logic [FB_W-1:0]   hold_bits;

  assign load = !out_valid || out_ready;
  assign pop  = load && !hold && pop_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hold      <= 1'b0;
    end else if (load) begin
      if (hold) begin
        out_valid <= 1'b1;
        hold      <= 1'b0;
      end else begin
        out_valid <= pop_valid;
        hold      <= pop_valid && pop_entry.two;
      end
    end
  end

  // output word and held second byte
  always_ff @(posedge clk) begin
    if (load) begin
      if (hold) begin
        frame_byte <= hold_byte;
        frame_end  <= hold_end;
        frame_bits <= hold_bits;
      end else if (pop_valid) begin
        frame_byte <= pop_entry.byte0;
        hold_byte  <= pop_entry.byte1;
        hold_end   <= pop_entry.last;
        hold_bits  <= pop_entry.bits;
        if (pop_entry.two) begin
          frame_end  <= 1'b0;
          frame_bits <= '0;
        end else begin
          frame_end  <= pop_entry.last;
          frame_bits <= pop_entry.bits;
        end
      end
    end
  end

endmodule

// File: tb/sv/frame_packing_checker.sv
// ----------------------------------------------------------------------------
// frame_packing_checker
// Watches both channels of the parity bit frame packer and predicts every
// frame word from the accepted data words. Each frame word that comes out is
// checked field by field against the oldest prediction. Mismatches go into a
// count that the testbench top reads.
// ----------------------------------------------------------------------------
module frame_packing_checker import pbfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [DATA_W-1:0] data_byte,
  input  logic              parity_bit,
  input  logic              last_byte,
  input  logic [LB_W-1:0]   last_bits,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [DATA_W-1:0] frame_byte,
  input  logic              frame_end,
  input  logic [FB_W-1:0]   frame_bits,
  output int                fail_count,
  output int                outstanding
);

  // data bits plus the parity bit that follows them on the air
  localparam int AIR_BITS = DATA_W + 1;

  typedef struct packed {
    logic [DATA_W-1:0] fbyte;
    logic              fend;
    logic [FB_W-1:0]   fbits;
  } frame_word_t;

  frame_word_t expected_words[$];

  // predicted packer state
  logic [DATA_W-1:0]     held_bits;
  logic [PEND_CNT_W-1:0] held_count;
  logic                  frame_start;
  int                    data_total;

  function automatic frame_word_t make_word(input logic [DATA_W-1:0] b, input logic e,
                                            input int n);
    frame_word_t w;
    w.fbyte = b;
    w.fend  = e;
    w.fbits = FB_W'(n);
    return w;
  endfunction

  task automatic clear_frame();
    held_bits   = '0;
    held_count  = '0;
    frame_start = 1'b1;
    data_total  = 0;
  endtask

  // append one data word to the air stream and queue the frame words it yields
  task automatic pack_word(input logic [DATA_W-1:0] data, input logic par, input logic last,
                           input logic [LB_W-1:0] lb_raw);
    logic [ACC_W-1:0] acc;
    int lb;
    int cnt;
    int total;
    int used;
    lb = (lb_raw == 0 || lb_raw > DATA_W) ? DATA_W : int'(lb_raw);
    if (last && frame_start) begin
      // single word frame goes out untouched
      expected_words.push_back(make_word(data, 1'b1, lb));
      clear_frame();
    end else begin
      acc = ACC_W'(held_bits) | (ACC_W'(data) << held_count)
          | (ACC_W'(par) << (held_count + DATA_W));
      if (!last) begin
        expected_words.push_back(make_word(acc[7:0], 1'b0, 0));
        acc = acc >> 8;
        cnt = held_count + AIR_BITS - 8;
        if (cnt >= 8) begin
          expected_words.push_back(make_word(acc[7:0], 1'b0, 0));
          acc = acc >> 8;
          cnt = cnt - 8;
        end
        held_bits   = acc[7:0];
        held_count  = PEND_CNT_W'(cnt);
        frame_start = 1'b0;
        data_total  = (data_total + DATA_W > BIT_LIMIT) ? BIT_LIMIT : data_total + DATA_W;
      end else begin
        // flush: the parity of the final word counts only when it is full
        total = data_total + lb;
        if (total > BIT_LIMIT) total = BIT_LIMIT;
        used = held_count + lb + ((lb == DATA_W) ? 1 : 0);
        if (used > 8) begin
          expected_words.push_back(make_word(acc[7:0], 1'b0, 0));
          expected_words.push_back(make_word(acc[15:8], 1'b1, total + total / 8));
        end else begin
          expected_words.push_back(make_word(acc[7:0], 1'b1, total + total / 8));
        end
        clear_frame();
      end
    end
  endtask

  // predict on accepted inputs, compare on accepted outputs
  always @(posedge clk) begin : monitor
    frame_word_t want;
    int errors;
    errors = 0;
    if (rst) begin
      clear_frame();
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) pack_word(data_byte, parity_bit, last_byte, last_bits);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word: frame_byte %02h frame_end %0d frame_bits %0d",
                   $time, frame_byte, frame_end, frame_bits);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (frame_byte !== want.fbyte) begin
            $display("%0t: frame_byte expected %02h actual %02h", $time, want.fbyte, frame_byte);
            errors++;
          end
          if (frame_end !== want.fend) begin
            $display("%0t: frame_end expected %0d actual %0d", $time, want.fend, frame_end);
            errors++;
          end
          if (frame_bits !== want.fbits) begin
            $display("%0t: frame_bits expected %0d actual %0d", $time, want.fbits, frame_bits);
            errors++;
          end
        end
      end
      fail_count <= fail_count + errors;
    end
    outstanding <= expected_words.size();
  end

endmodule

// File: tb/sv/parity_bit_frame_packer_test.sv
// ----------------------------------------------------------------------------
// parity_bit_frame_packer_test
// Drives data words into the parity bit frame packer, first a directed set
// of frames and then random frames of mostly short length with two long ones
// that reach the bit count limit. Both sides idle at random, and the output
// side holds off once for a long stretch. The checker does the comparing.
// ----------------------------------------------------------------------------
module parity_bit_frame_packer_test;
  import pbfp_pkg::*;

  localparam int RUN_ITEMS   = 1000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 120;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [DATA_W-1:0] data_byte = '0;
  logic              parity_bit = 1'b0;
  logic              last_byte = 1'b0;
  logic [LB_W-1:0]   last_bits = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] frame_byte;
  logic              frame_end;
  logic [FB_W-1:0]   frame_bits;
  int                fail_count;
  int                outstanding;
  int                cycles = 0;
  int                words_sent = 0;

  parity_bit_frame_packer dut (.*);

  frame_packing_checker watcher (.*);

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // idle length: mostly none or short, a few long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic int frame_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 1;
    if (r < 85) return $urandom_range(2, 5);
    if (r < 97) return $urandom_range(6, 20);
    return $urandom_range(21, 40);
  endfunction

  // final word bit count, now and then out of range
  function automatic logic [LB_W-1:0] pick_last_bits();
    if ($urandom_range(0, 9) == 0) return LB_W'($urandom_range(0, 15));
    return LB_W'($urandom_range(1, DATA_W));
  endfunction

  // offer one word and wait for it to be taken; returns on a falling edge
  task automatic send_word(input logic [DATA_W-1:0] d, input logic p, input logic l,
                           input logic [LB_W-1:0] lb, input bit burst);
    int gap;
    gap = burst ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= d;
    parity_bit <= p;
    last_byte  <= l;
    last_bits  <= lb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_frame(input int nbytes, input bit burst);
    logic [LB_W-1:0] lb;
    for (int i = 0; i < nbytes; i++) begin
      lb = (i == nbytes - 1) ? pick_last_bits() : LB_W'($urandom_range(0, 15));
      send_word(DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), i == nbytes - 1,
                lb, burst);
    end
  endtask

  // output side: random stalls plus one long hold-off
  initial begin : drain
    int stall;
    int round;
    round = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      round++;
      stall = (round == 40) ? LONG_HOLD : idle_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int frames;
    int nbytes;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // single word frames: full, one bit, bit count zero and above range
    send_word(8'hFF, 1'b1, 1'b1, 4'd8, 1'b0);
    send_word(8'h00, 1'b0, 1'b1, 4'd1, 1'b0);
    send_word(8'hA5, 1'b1, 1'b1, 4'd0, 1'b0);
    send_word(8'h5A, 1'b0, 1'b1, 4'd15, 1'b0);
    // two word frames at the value extremes
    send_word(8'hFF, 1'b1, 1'b0, 4'd0, 1'b0);
    send_word(8'h00, 1'b1, 1'b1, 4'd8, 1'b0);
    send_word(8'h00, 1'b0, 1'b0, 4'd15, 1'b1);
    send_word(8'hFF, 1'b1, 1'b1, 4'd1, 1'b1);
    // walk the held bit count up to seven, then a full final word spills over
    for (int i = 0; i < 7; i++) send_word(8'h01 << i, 1'(i), 1'b0, 4'd3, 1'b0);
    send_word(8'hE7, 1'b1, 1'b1, 4'd8, 1'b0);
    // final word with bits beyond its count, bit count above range
    send_word(8'hC3, 1'b0, 1'b0, 4'd0, 1'b0);
    send_word(8'h3C, 1'b1, 1'b0, 4'd0, 1'b0);
    send_word(8'h81, 1'b1, 1'b1, 4'd9, 1'b0);
    send_word(8'h96, 1'b1, 1'b0, 4'd0, 1'b0);
    send_word(8'h69, 1'b0, 1'b0, 4'd0, 1'b0);
    send_word(8'hFE, 1'b1, 1'b1, 4'd1, 1'b0);

    // random frames; two long ones reach and pass the bit count limit
    words_sent = 0;
    frames = 0;
    while (words_sent < RUN_ITEMS) begin
      if (frames == 3) nbytes = MAX_FRAME_BYTES;
      else if (frames == 50) nbytes = MAX_FRAME_BYTES + $urandom_range(1, 24);
      else nbytes = frame_length();
      send_frame(nbytes, $urandom_range(0, 3) == 0);
      frames++;
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
